// File: rtl/gnrm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnrm_pkg
// Shared types and constants for the gated nearest rectangle matcher.
// ----------------------------------------------------------------------------
package gnrm_pkg;

   // coordinate and derived widths
   localparam int CoordBits    = 12;
   localparam int CentreBits   = CoordBits + 1;
   localparam int SqBits       = 2 * CentreBits;
   localparam int DistBits     = SqBits + 1;
   localparam int GateBits     = 13;
   localparam int GateSqBits   = 2 * GateBits;
   localparam int CmpBits      = (DistBits > GateSqBits) ? DistBits : GateSqBits;
   localparam int IdxBits      = 6;
   localparam int OutCentreBits = 13;

   // queue between front and back
   localparam int QueueDepth   = 4;
   localparam int QueuePtrBits = $clog2(QueueDepth);
   localparam int QueueCntBits = $clog2(QueueDepth + 1);

   // command codes
   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_CAND  = 2'd1;
   localparam logic [1:0] CMD_CLOSE = 2'd2;
   localparam logic [1:0] CMD_NONE  = 2'd3;

   localparam logic [GateBits-1:0]   GATE_RESET    = 13'd64;
   localparam logic [GateSqBits-1:0] GATE_SQ_RESET = 26'd4096;

   // input beat
   typedef struct packed {
      logic [1:0]           command;
      logic [CoordBits-1:0] rect_x;
      logic [CoordBits-1:0] rect_y;
      logic [CoordBits-1:0] rect_width;
      logic [CoordBits-1:0] rect_height;
      logic                 last_candidate;
   } req_type;

   // result beat
   typedef struct packed {
      logic                     matched;
      logic [IdxBits-1:0]       matched_index;
      logic                     track_active;
      logic [OutCentreBits-1:0] centre_x;
      logic [OutCentreBits-1:0] centre_y;
   } rsp_type;

   // classified item handed from front to back
   typedef struct packed {
      logic [1:0]            command;
      logic                  last_candidate;
      logic [CentreBits-1:0] centre_x;
      logic [CentreBits-1:0] centre_y;
   } work_type;

endpackage

// File: rtl/gnrm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnrm_front
// Accepts input beats, drops unused commands and forms rectangle centres.
// ----------------------------------------------------------------------------
module gnrm_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  gnrm_pkg::req_type req_data,
   output logic              work_valid,
   input  logic              work_stall,
   output gnrm_pkg::work_type work_data
);

   logic               valid_ff, valid_in;
   gnrm_pkg::work_type item_ff, item_in;
   logic               can_load;
   logic               accept;

   // take a beat when the stage is empty or draining this cycle
   assign can_load  = !valid_ff || !work_stall;
   assign req_stall = !can_load;
   assign accept    = req_valid && can_load;

   // classify and form centres
   always_comb begin
      item_in                = item_ff;
      valid_in               = valid_ff && work_stall;
      if (accept && req_data.command != gnrm_pkg::CMD_NONE) begin
         valid_in                = 1'b1;
         item_in.command         = req_data.command;
         item_in.last_candidate  = req_data.last_candidate;
         item_in.centre_x = gnrm_pkg::CentreBits'(req_data.rect_x)
                          + gnrm_pkg::CentreBits'(req_data.rect_width >> 1);
         item_in.centre_y = gnrm_pkg::CentreBits'(req_data.rect_y)
                          + gnrm_pkg::CentreBits'(req_data.rect_height >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign work_valid = valid_ff;
   assign work_data  = item_ff;

endmodule

// File: rtl/gnrm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnrm_queue
// Short register queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module gnrm_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_stall,
   input  gnrm_pkg::work_type in_data,
   output logic               out_valid,
   input  logic               out_stall,
   output gnrm_pkg::work_type out_data
);

   gnrm_pkg::work_type entry_ff [gnrm_pkg::QueueDepth];
   logic [gnrm_pkg::QueuePtrBits-1:0] wr_ptr_ff, wr_ptr_in;
   logic [gnrm_pkg::QueuePtrBits-1:0] rd_ptr_ff, rd_ptr_in;
   logic [gnrm_pkg::QueueCntBits-1:0] count_ff, count_in;
   logic push;
   logic pop;

   assign in_stall  = (count_ff == gnrm_pkg::QueueCntBits'(gnrm_pkg::QueueDepth));
   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && !out_stall;

   // advance pointers and fill level
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the pushed beat
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// File: rtl/gnrm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnrm_back
// Track state, distance pipeline, best-candidate search and result register.
// ----------------------------------------------------------------------------
module gnrm_back #(
   parameter int MaxCandidates = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [gnrm_pkg::GateBits-1:0]   csr_wdata,
   input  logic                            work_valid,
   output logic                            work_stall,
   input  gnrm_pkg::work_type              work_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output gnrm_pkg::rsp_type               rsp_data
);

   localparam int CntBits = $clog2(MaxCandidates + 1);

   typedef struct packed {
      gnrm_pkg::work_type          work;
      logic [gnrm_pkg::SqBits-1:0] dx_sq;
      logic [gnrm_pkg::SqBits-1:0] dy_sq;
   } dist_type;

   // gate register and its square
   logic [gnrm_pkg::GateBits-1:0]   gate_ff;
   logic [gnrm_pkg::GateSqBits-1:0] gate_sq_ff;

   // track and frame state
   logic                              active_ff, active_in;
   logic [gnrm_pkg::CentreBits-1:0]   track_x_ff, track_x_in;
   logic [gnrm_pkg::CentreBits-1:0]   track_y_ff, track_y_in;
   logic [gnrm_pkg::DistBits-1:0]     best_dist_ff, best_dist_in;
   logic [CntBits-1:0]                best_pos_ff, best_pos_in;
   logic [gnrm_pkg::CentreBits-1:0]   best_x_ff, best_x_in;
   logic [gnrm_pkg::CentreBits-1:0]   best_y_ff, best_y_in;
   logic                              found_ff, found_in;
   logic [CntBits-1:0]                count_ff, count_in;

   // pipeline stages
   logic     s1_valid_ff, s1_valid_in;
   dist_type s1_ff, s1_in;
   logic     s2_valid_ff, s2_valid_in;
   dist_type s2_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   gnrm_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // control
   logic s1_changes, s2_changes, hazard, is_cand;
   logic s1_free, s2_take, s2_fire, s1_load, out_free, emits;

   // candidate evaluation
   logic [gnrm_pkg::CentreBits-1:0] dx, dy;
   logic [gnrm_pkg::DistBits-1:0]   cand_dsq;
   logic in_range, take, close;
   logic                            nb_found;
   logic [CntBits-1:0]              nb_pos;
   logic [gnrm_pkg::CentreBits-1:0] nb_x, nb_y;

   // latch gate and keep its square registered
   always_ff @(posedge clock) begin
      if (reset) begin
         gate_ff    <= gnrm_pkg::GATE_RESET;
         gate_sq_ff <= gnrm_pkg::GATE_SQ_RESET;
      end else begin
         if (csr_we) begin
            gate_ff <= csr_wdata;
         end
         gate_sq_ff <= gnrm_pkg::GateSqBits'(gate_ff) * gnrm_pkg::GateSqBits'(gate_ff);
      end
   end

   // hold candidates while a start or close ahead may move the track centre
   assign s1_changes = (s1_ff.work.command != gnrm_pkg::CMD_CAND)
                    || s1_ff.work.last_candidate;
   assign s2_changes = (s2_ff.work.command != gnrm_pkg::CMD_CAND)
                    || s2_ff.work.last_candidate;
   assign hazard  = (s1_valid_ff && s1_changes) || (s2_valid_ff && s2_changes);
   assign is_cand = (work_data.command == gnrm_pkg::CMD_CAND);

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emits    = active_ff && ((s2_ff.work.command == gnrm_pkg::CMD_CLOSE)
                  || ((s2_ff.work.command == gnrm_pkg::CMD_CAND)
                      && s2_ff.work.last_candidate));
   assign s2_fire  = s2_valid_ff && (!emits || out_free);
   assign s2_take  = !s2_valid_ff || s2_fire;
   assign s1_free  = !s1_valid_ff || s2_take;
   assign s1_load  = work_valid && s1_free && !(is_cand && hazard);
   assign work_stall = !(s1_free && !(is_cand && hazard));

   // stage 1: absolute offsets and their squares
   always_comb begin
      dx = (work_data.centre_x > track_x_ff) ? work_data.centre_x - track_x_ff
                                             : track_x_ff - work_data.centre_x;
      dy = (work_data.centre_y > track_y_ff) ? work_data.centre_y - track_y_ff
                                             : track_y_ff - work_data.centre_y;
      s1_in       = s1_ff;
      s1_valid_in = s1_valid_ff && !s2_take;
      if (s1_load) begin
         s1_valid_in = 1'b1;
         s1_in.work  = work_data;
         s1_in.dx_sq = gnrm_pkg::SqBits'(dx) * gnrm_pkg::SqBits'(dx);
         s1_in.dy_sq = gnrm_pkg::SqBits'(dy) * gnrm_pkg::SqBits'(dy);
      end
      s2_valid_in = s2_take ? s1_valid_ff : s2_valid_ff;
   end

   // stage 2: sum, gate and best update, frame close
   always_comb begin
      cand_dsq = gnrm_pkg::DistBits'(s2_ff.dx_sq) + gnrm_pkg::DistBits'(s2_ff.dy_sq);
      in_range = (count_ff < CntBits'(MaxCandidates));
      take = (s2_ff.work.command == gnrm_pkg::CMD_CAND) && active_ff && in_range
          && (gnrm_pkg::CmpBits'(cand_dsq) < gnrm_pkg::CmpBits'(gate_sq_ff))
          && (cand_dsq < best_dist_ff);
      nb_found = found_ff || take;
      nb_pos   = take ? count_ff : best_pos_ff;
      nb_x     = take ? s2_ff.work.centre_x : best_x_ff;
      nb_y     = take ? s2_ff.work.centre_y : best_y_ff;
      close    = 1'b0;

      active_in    = active_ff;
      track_x_in   = track_x_ff;
      track_y_in   = track_y_ff;
      best_dist_in = best_dist_ff;
      best_pos_in  = best_pos_ff;
      best_x_in    = best_x_ff;
      best_y_in    = best_y_ff;
      found_in     = found_ff;
      count_in     = count_ff;

      if (s2_fire) begin
         case (s2_ff.work.command)
            gnrm_pkg::CMD_START: begin
               track_x_in = s2_ff.work.centre_x;
               track_y_in = s2_ff.work.centre_y;
               active_in  = 1'b1;
               close      = 1'b0;
            end
            gnrm_pkg::CMD_CAND: begin
               if (active_ff) begin
                  if (in_range) begin
                     count_in = count_ff + 1'b1;
                  end
                  if (take) begin
                     best_dist_in = cand_dsq;
                     best_pos_in  = nb_pos;
                     best_x_in    = nb_x;
                     best_y_in    = nb_y;
                     found_in     = 1'b1;
                  end
                  close = s2_ff.work.last_candidate;
               end
            end
            gnrm_pkg::CMD_CLOSE: begin
               close = active_ff;
            end
            default: begin
               close = 1'b0;
            end
         endcase
         if (close) begin
            if (nb_found) begin
               track_x_in = nb_x;
               track_y_in = nb_y;
            end else begin
               active_in = 1'b0;
            end
         end
         // start and close both open a fresh frame
         if (close || s2_ff.work.command == gnrm_pkg::CMD_START) begin
            best_dist_in = '1;
            best_pos_in  = '0;
            best_x_in    = '0;
            best_y_in    = '0;
            found_in     = 1'b0;
            count_in     = '0;
         end
      end
   end

   // result register
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (s2_fire && emits) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.matched        = nb_found;
         rsp_data_in.matched_index  = nb_found ? gnrm_pkg::IdxBits'(nb_pos) : '0;
         rsp_data_in.track_active   = nb_found;
         rsp_data_in.centre_x = gnrm_pkg::OutCentreBits'(nb_found ? nb_x : track_x_ff);
         rsp_data_in.centre_y = gnrm_pkg::OutCentreBits'(nb_found ? nb_y : track_y_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         track_x_ff   <= '0;
         track_y_ff   <= '0;
         best_dist_ff <= '1;
         best_pos_ff  <= '0;
         best_x_ff    <= '0;
         best_y_ff    <= '0;
         found_ff     <= 1'b0;
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         track_x_ff   <= track_x_in;
         track_y_ff   <= track_y_in;
         best_dist_ff <= best_dist_in;
         best_pos_ff  <= best_pos_in;
         best_x_ff    <= best_x_in;
         best_y_ff    <= best_y_in;
         found_ff     <= found_in;
         count_ff     <= count_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      if (s2_take) begin
         s2_ff <= s1_ff;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/gated_nearest_rect_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gated_nearest_rect_matcher
// Single-object tracker: picks the nearest gated candidate rectangle per frame.
// ----------------------------------------------------------------------------
// Candidate beats of one frame are taken at one per cycle unless a stall holds
// them. After each start beat and each frame close (a last candidate or an
// empty-frame close) the distance stage holds the next candidate until that
// beat has left the compare stage, since that candidate must be measured
// against the track centre the close has just moved. A result leaves through
// the input register, queue, offset-square stage, compare stage and result
// register after its closing beat is taken. A four-entry queue keeps the input
// side running while the result side is stalled. A gate write on csr_wdata is
// registered, and its square is registered from it before the compare uses it.
module gated_nearest_rect_matcher #(
   parameter int MAX_CANDIDATES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [gnrm_pkg::GateBits-1:0] csr_wdata,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  gnrm_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output gnrm_pkg::rsp_type             rsp_data
);

   logic               front_valid, front_stall;
   gnrm_pkg::work_type front_data;
   logic               queue_valid, queue_stall;
   gnrm_pkg::work_type queue_data;

   // classify beats and form centres
   gnrm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .work_valid (front_valid),
      .work_stall (front_stall),
      .work_data  (front_data)
   );

   // decouple front and back
   gnrm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_stall  (front_stall),
      .in_data   (front_data),
      .out_valid (queue_valid),
      .out_stall (queue_stall),
      .out_data  (queue_data)
   );

   // match against the track and report
   gnrm_back #(
      .MaxCandidates (MAX_CANDIDATES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .work_valid (queue_valid),
      .work_stall (queue_stall),
      .work_data  (queue_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

// File: tb/sv/tb_gated_nearest_rect_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gated_nearest_rect_matcher
// Self-checking bench for the gated nearest rectangle matcher.
// ----------------------------------------------------------------------------
// A built-in tracker model follows every accepted request beat. It keeps the
// track centre, the per-frame best candidate and the gate. Each frame close
// queues the report the block should send. Every result beat is checked
// against the oldest queued report.
// The run covers these parts in turn:
//    - directed frames: field extremes, ties, gate edge, ignored commands,
//      empty-frame close, restart mid-frame
//    - gate extremes
//    - candidate overflow past the frame limit
//    - a long result stall that backs the block up
//    - random frames under several gates, with random gaps and stalls on
//      both sides, and a clean run at the end
// ----------------------------------------------------------------------------
module tb_gated_nearest_rect_matcher;

   localparam int MaxCandidates = 64;
   localparam int CoordMax      = (1 << gnrm_pkg::CoordBits) - 1;
   localparam int GateMax       = (1 << gnrm_pkg::GateBits) - 1;
   localparam int LatencyPause  = 10;
   localparam int QuietLimit    = 2000;
   localparam int LongHold      = 150;

   logic    clock;
   logic    reset;
   logic    csr_we;
   logic [gnrm_pkg::GateBits-1:0] csr_wdata;
   logic    req_valid;
   logic    req_stall;
   gnrm_pkg::req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   gnrm_pkg::rsp_type rsp_data;

   // tracker model state
   logic [gnrm_pkg::GateBits-1:0]   gate_setting = gnrm_pkg::GATE_RESET;
   logic [gnrm_pkg::CentreBits-1:0] trk_cx = '0;
   logic [gnrm_pkg::CentreBits-1:0] trk_cy = '0;
   logic                            trk_active = 1'b0;
   longint                          best_dsq;
   logic [gnrm_pkg::IdxBits-1:0]    best_pos;
   logic [gnrm_pkg::CentreBits-1:0] best_cx;
   logic [gnrm_pkg::CentreBits-1:0] best_cy;
   logic                            frame_found;
   int                              cand_count;

   gnrm_pkg::rsp_type frame_reports[$];

   int mismatch_count  = 0;
   int quiet_cycles    = 0;
   int hold_off_cycles = 0;
   bit sender_gaps     = 1'b0;
   bit reader_stalls   = 1'b0;

   gated_nearest_rect_matcher #(
      .MAX_CANDIDATES(MaxCandidates)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // 20 ns clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // ------------------------------------------------------------------------
   // Tracker model
   // ------------------------------------------------------------------------

   function automatic void clear_frame();
      best_dsq    = 64'h7FF_FFFF;
      best_pos    = '0;
      best_cx     = '0;
      best_cy     = '0;
      frame_found = 1'b0;
      cand_count  = 0;
   endfunction

   // close the frame: move the track to the match or drop it
   function automatic gnrm_pkg::rsp_type close_frame_report();
      gnrm_pkg::rsp_type report;
      if (frame_found) begin
         trk_cx = best_cx;
         trk_cy = best_cy;
      end else begin
         trk_active = 1'b0;
      end
      report.matched       = frame_found;
      report.matched_index = frame_found ? best_pos : '0;
      report.track_active  = trk_active;
      report.centre_x      = trk_cx;
      report.centre_y      = trk_cy;
      clear_frame();
      return report;
   endfunction

   // advance the model by one request beat; returns 1 when a report is due
   function automatic bit track_beat(input gnrm_pkg::req_type beat,
                                     output gnrm_pkg::rsp_type report);
      logic [gnrm_pkg::CentreBits-1:0] cx;
      logic [gnrm_pkg::CentreBits-1:0] cy;
      longint dx;
      longint dy;
      longint dist_sq;
      longint gate_sq;
      bit     produced;
      produced = 1'b0;
      report   = '0;
      cx = {1'b0, beat.rect_x} + {2'b00, beat.rect_width[gnrm_pkg::CoordBits-1:1]};
      cy = {1'b0, beat.rect_y} + {2'b00, beat.rect_height[gnrm_pkg::CoordBits-1:1]};
      if (beat.command == gnrm_pkg::CMD_START) begin
         trk_cx     = cx;
         trk_cy     = cy;
         trk_active = 1'b1;
         clear_frame();
      end else if (beat.command != gnrm_pkg::CMD_NONE && trk_active) begin
         // compare only the first MaxCandidates of a frame
         if (beat.command == gnrm_pkg::CMD_CAND && cand_count < MaxCandidates) begin
            dx = (cx > trk_cx) ? longint'(cx) - longint'(trk_cx)
                               : longint'(trk_cx) - longint'(cx);
            dy = (cy > trk_cy) ? longint'(cy) - longint'(trk_cy)
                               : longint'(trk_cy) - longint'(cy);
            dist_sq = dx * dx + dy * dy;
            gate_sq = longint'(gate_setting) * longint'(gate_setting);
            if (dist_sq < gate_sq && dist_sq < best_dsq) begin
               best_dsq    = dist_sq;
               best_pos    = cand_count[gnrm_pkg::IdxBits-1:0];
               best_cx     = cx;
               best_cy     = cy;
               frame_found = 1'b1;
            end
            cand_count++;
         end
         if (beat.command == gnrm_pkg::CMD_CLOSE || beat.last_candidate) begin
            report   = close_frame_report();
            produced = 1'b1;
         end
      end
      return produced;
   endfunction

   // ------------------------------------------------------------------------
   // Beat builders
   // ------------------------------------------------------------------------

   function automatic logic [gnrm_pkg::CoordBits-1:0] fit_coord(input int v);
      if (v < 0)
         return '0;
      if (v > CoordMax)
         return '1;
      return v[gnrm_pkg::CoordBits-1:0];
   endfunction

   function automatic gnrm_pkg::req_type rect_beat(input logic [1:0] cmd, input int x,
                                                   input int y, input int w, input int h,
                                                   input bit last);
      gnrm_pkg::req_type beat;
      beat.command        = cmd;
      beat.rect_x         = fit_coord(x);
      beat.rect_y         = fit_coord(y);
      beat.rect_width     = fit_coord(w);
      beat.rect_height    = fit_coord(h);
      beat.last_candidate = last;
      return beat;
   endfunction

   function automatic gnrm_pkg::req_type random_beat();
      gnrm_pkg::req_type beat;
      beat.command        = 2'($urandom_range(0, 3));
      beat.rect_x         = gnrm_pkg::CoordBits'($urandom_range(0, CoordMax));
      beat.rect_y         = gnrm_pkg::CoordBits'($urandom_range(0, CoordMax));
      beat.rect_width     = gnrm_pkg::CoordBits'($urandom_range(0, CoordMax));
      beat.rect_height    = gnrm_pkg::CoordBits'($urandom_range(0, CoordMax));
      beat.last_candidate = 1'($urandom_range(0, 1));
      return beat;
   endfunction

   // mostly small sizes, sometimes any size
   function automatic int pick_size();
      return ($urandom_range(0, 3) == 0) ? $urandom_range(0, CoordMax)
                                         : $urandom_range(0, 255);
   endfunction

   // rectangle whose centre lies within spread of the current track centre
   function automatic gnrm_pkg::req_type near_beat(input logic [1:0] cmd, input int spread,
                                                   input bit last);
      int cx;
      int cy;
      int w;
      int h;
      w  = pick_size();
      h  = pick_size();
      cx = int'(trk_cx) + int'($urandom_range(0, 2 * spread)) - spread;
      cy = int'(trk_cy) + int'($urandom_range(0, 2 * spread)) - spread;
      return rect_beat(cmd, cx - w / 2, cy - h / 2, w, h, last);
   endfunction

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   // send one beat; call and return at a falling edge
   task automatic send_beat(input gnrm_pkg::req_type beat);
      gnrm_pkg::rsp_type report;
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      forever begin
         @(posedge clock);
         if (!req_stall)
            break;
      end
      if (track_beat(beat, report))
         frame_reports = {frame_reports, report};
      @(negedge clock);
   endtask

   // one frame of candidates near the track, closed by last mark or command
   task automatic send_frame(input int count, input int spread, input bit close_by_command);
      for (int i = 0; i < count; i++)
         send_beat(near_beat(gnrm_pkg::CMD_CAND, spread,
                             !close_by_command && i == count - 1));
      if (close_by_command)
         send_beat(near_beat(gnrm_pkg::CMD_CLOSE, spread, 1'($urandom_range(0, 1))));
   endtask

   // hold the sender until every report is back and the pipe is empty
   task automatic drain();
      req_valid <= 1'b0;
      while (frame_reports.size() != 0)
         @(negedge clock);
      repeat (LatencyPause) @(negedge clock);
   endtask

   task automatic write_gate(input int value);
      csr_we    <= 1'b1;
      csr_wdata <= value[gnrm_pkg::GateBits-1:0];
      gate_setting = value[gnrm_pkg::GateBits-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Result side: stall generator and checker
   // ------------------------------------------------------------------------

   initial begin
      int n;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            n = hold_off_cycles;
            hold_off_cycles = 0;
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if (reader_stalls && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 5)) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic note_mismatch(input string what, input gnrm_pkg::rsp_type want,
                                input gnrm_pkg::rsp_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s: expected matched=%0d index=%0d active=%0d centre=(%0d,%0d)",
                  $time, what, want.matched, want.matched_index, want.track_active,
                  want.centre_x, want.centre_y);
      if (mismatch_count <= 10)
         $display("%0t: %s: actual   matched=%0d index=%0d active=%0d centre=(%0d,%0d)",
                  $time, what, got.matched, got.matched_index, got.track_active,
                  got.centre_x, got.centre_y);
   endtask

   // compare each result beat with the oldest queued report
   always @(posedge clock) begin
      gnrm_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (frame_reports.size() == 0) begin
            note_mismatch("result beat with no report pending", '0, rsp_data);
         end else begin
            want = frame_reports.pop_front();
            if (rsp_data.matched !== want.matched ||
                rsp_data.matched_index !== want.matched_index ||
                rsp_data.track_active !== want.track_active ||
                rsp_data.centre_x !== want.centre_x ||
                rsp_data.centre_y !== want.centre_y)
               note_mismatch("result beat differs", want, rsp_data);
         end
      end
   end

   // end the run when no beat moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // hand-picked frames at the default gate of 64
   task automatic test_directed();
      gnrm_pkg::req_type beat;
      // track inactive: candidate, close and the unused command are dropped
      beat = random_beat();
      beat.command = gnrm_pkg::CMD_CAND;
      beat.last_candidate = 1'b1;
      send_beat(beat);
      beat = random_beat();
      beat.command = gnrm_pkg::CMD_CLOSE;
      send_beat(beat);
      beat = random_beat();
      beat.command = gnrm_pkg::CMD_NONE;
      send_beat(beat);
      // largest rectangle: centre at the top of the range, exact match
      send_beat(rect_beat(gnrm_pkg::CMD_START, CoordMax, CoordMax, CoordMax, CoordMax, 1'b1));
      send_beat(rect_beat(gnrm_pkg::CMD_CAND, CoordMax, CoordMax, CoordMax, CoordMax, 1'b1));
      // gate edge, first strict minimum, tie kept, far last candidate
      send_beat(rect_beat(gnrm_pkg::CMD_START, 0, 0, 0, 0, 1'b0));
      send_beat(rect_beat(gnrm_pkg::CMD_CAND, 64, 0, 0, 0, 1'b0));
      send_beat(rect_beat(gnrm_pkg::CMD_CAND, 63, 0, 0, 0, 1'b0));
      send_beat(rect_beat(gnrm_pkg::CMD_CAND, 0, 63, 0, 0, 1'b0));
      send_beat(rect_beat(gnrm_pkg::CMD_CAND, 100, 0, 0, 0, 1'b1));
      // unused command while active, then close of an empty frame
      beat = random_beat();
      beat.command = gnrm_pkg::CMD_NONE;
      send_beat(beat);
      send_beat(rect_beat(gnrm_pkg::CMD_CLOSE, 0, 0, 0, 0, 1'b0));
      send_beat(rect_beat(gnrm_pkg::CMD_CAND, 63, 0, 0, 0, 1'b1));
      // restart mid-frame drops the partial frame
      send_beat(rect_beat(gnrm_pkg::CMD_START, 100, 100, 0, 0, 1'b0));
      send_beat(rect_beat(gnrm_pkg::CMD_CAND, 101, 100, 0, 0, 1'b0));
      send_beat(rect_beat(gnrm_pkg::CMD_START, 200, 200, 1, 1, 1'b0));
      send_beat(rect_beat(gnrm_pkg::CMD_CLOSE, 0, 0, 0, 0, 1'b1));
      // odd sizes round down; close by command after a match
      send_beat(rect_beat(gnrm_pkg::CMD_START, 1000, 2000, 40, 21, 1'b0));
      send_beat(rect_beat(gnrm_pkg::CMD_CAND, 1000, 2000, 41, 21, 1'b0));
      send_beat(rect_beat(gnrm_pkg::CMD_CAND, 1030, 2000, 0, 20, 1'b0));
      send_beat(rect_beat(gnrm_pkg::CMD_CLOSE, 0, 0, 0, 0, 1'b0));
      send_beat(rect_beat(gnrm_pkg::CMD_CAND, 1010, 1995, 2, 30, 1'b1));
   endtask

   task automatic test_gate_extremes();
      int gate_list[4];
      gate_list = '{0, 1, GateMax, 0};
      gate_list[3] = $urandom_range(2, GateMax - 1);
      foreach (gate_list[g]) begin
         drain();
         write_gate(gate_list[g]);
         // exact centre: misses only at gate zero
         send_beat(rect_beat(gnrm_pkg::CMD_START, 0, 0, 0, 0, 1'b0));
         send_beat(rect_beat(gnrm_pkg::CMD_CAND, 0, 0, 1, 1, 1'b1));
         // one pixel off: misses at gate one
         send_beat(rect_beat(gnrm_pkg::CMD_START, 0, 0, 0, 0, 1'b0));
         send_beat(rect_beat(gnrm_pkg::CMD_CAND, 1, 0, 0, 0, 1'b1));
         // far corner never matches, far edge only under a gate wider than 6142
         send_beat(rect_beat(gnrm_pkg::CMD_START, 0, 0, 0, 0, 1'b0));
         send_beat(rect_beat(gnrm_pkg::CMD_CAND, CoordMax, CoordMax, CoordMax, CoordMax,
                             1'b0));
         send_beat(rect_beat(gnrm_pkg::CMD_CAND, CoordMax, 0, CoordMax, 0, 1'b1));
         send_frame(4, (gate_list[g] > 3000) ? 3000 : gate_list[g] + 1, 1'b0);
      end
   endtask

   task automatic test_candidate_overflow();
      drain();
      write_gate(gnrm_pkg::GATE_RESET);
      send_beat(rect_beat(gnrm_pkg::CMD_START, 2000, 2000, 0, 0, 1'b0));
      // match at the last compared slot; an exact hit past the limit is dropped
      for (int i = 0; i < MaxCandidates + 6; i++) begin
         if (i == MaxCandidates - 1)
            send_beat(rect_beat(gnrm_pkg::CMD_CAND, 2003, 2004, 0, 0, 1'b0));
         else if (i == MaxCandidates + 1)
            send_beat(rect_beat(gnrm_pkg::CMD_CAND, 2000, 2000, 0, 0, 1'b0));
         else
            send_beat(rect_beat(gnrm_pkg::CMD_CAND, 2500, 2000, 0, 0,
                                i == MaxCandidates + 5));
      end
      // an all-miss frame past the limit closes on its last mark
      for (int i = 0; i < MaxCandidates + 2; i++)
         send_beat(rect_beat(gnrm_pkg::CMD_CAND, 100, 100, 0, 0, i == MaxCandidates + 1));
   endtask

   // stall results for a long stretch so the block backs up into its input
   task automatic test_long_stall();
      drain();
      sender_gaps   = 1'b0;
      reader_stalls = 1'b0;
      hold_off_cycles = LongHold;
      send_beat(near_beat(gnrm_pkg::CMD_START, 0, 1'b0));
      for (int i = 0; i < 24; i++)
         send_frame(1, 8, 1'b0);
      drain();
   endtask

   task automatic test_random_frames(input int beats, input int gate_low,
                                     input int gate_high, input bit idling);
      int sent;
      int pick;
      int n;
      int spread;
      gnrm_pkg::req_type beat;
      drain();
      write_gate($urandom_range(gate_low, gate_high));
      sender_gaps   = idling;
      reader_stalls = idling;
      sent = 0;
      while (sent < beats) begin
         pick   = $urandom_range(0, 99);
         spread = $urandom_range(0, int'(gate_setting) + int'(gate_setting) / 2 + 1);
         if (spread > 3000)
            spread = 3000;
         if (!trk_active || pick < 5) begin
            // new track: anywhere, or near the old centre
            if ($urandom_range(0, 1)) begin
               beat = random_beat();
               beat.command = gnrm_pkg::CMD_START;
            end else begin
               beat = near_beat(gnrm_pkg::CMD_START, 200, 1'($urandom_range(0, 1)));
            end
            send_beat(beat);
            sent++;
         end else if (pick < 85) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
            send_frame(n, spread, $urandom_range(0, 6) == 0);
            sent += n;
         end else if (pick < 90) begin
            // partial frame, left open
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
               send_beat(near_beat(gnrm_pkg::CMD_CAND, spread, 1'b0));
            sent += n;
         end else begin
            send_beat(random_beat());
            sent++;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_wdata = '0;
      clear_frame();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_gate_extremes();
      test_candidate_overflow();
      test_long_stall();
      test_random_frames(500, gnrm_pkg::GATE_RESET, gnrm_pkg::GATE_RESET, 1'b1);
      test_random_frames(300, 2, 400, 1'b1);
      for (int k = 0; k < 4; k++)
         test_random_frames(60, 0, GateMax, 1'b1);
      test_random_frames(400, gnrm_pkg::GATE_RESET, gnrm_pkg::GATE_RESET, 1'b0);

      drain();
      repeat (20) @(negedge clock);
      if (mismatch_count == 0 && frame_reports.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// File: files.f
rtl/gnrm_pkg.sv
rtl/gnrm_front.sv
rtl/gnrm_queue.sv
rtl/gnrm_back.sv
rtl/gated_nearest_rect_matcher.sv
tb/sv/tb_gated_nearest_rect_matcher.sv
